[hw/rtl/cfca_pkg.sv]
// ----------------------------------------------------------------------------
// cfca_pkg
// Shared widths, constants and types of the CO2 frame check / average unit.
// ----------------------------------------------------------------------------
package cfca_pkg;

    localparam int BYTE_W        = 8;
    localparam int READING_W     = 16;
    localparam int CONC_W        = 18;
    localparam int BASE_W        = 16;
    localparam int OFFS_W        = CONC_W + 2;
    localparam int POS_W         = 4;
    localparam int FRAME_BYTES   = 9;
    localparam int WINDOW_SIZE_D = 8;

    localparam logic [POS_W-1:0] POS_FIRST = POS_W'(1);
    localparam logic [POS_W-1:0] POS_HIGH  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LOW   = POS_W'(3);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_IDLE  = POS_W'(FRAME_BYTES);

    localparam logic [BASE_W-1:0]        CAL_BASE_RST = BASE_W'(400);
    localparam logic signed [CONC_W-1:0] CONC_MAX     = 18'sh1FFFF;
    localparam logic signed [CONC_W-1:0] CONC_MIN     = 18'sh20000;

    // end-of-frame event from the frame parser
    typedef struct packed {
        logic                 valid;
        logic                 good;
        logic                 cal;
        logic [READING_W-1:0] raw;
    } t_frame_evt;

endpackage

[hw/rtl/cfca_ifs.sv]
// ----------------------------------------------------------------------------
// cfca_in_if / cfca_out_if
// Valid/ready channels for received bytes and for frame results.
// ----------------------------------------------------------------------------
interface cfca_in_if;
    logic                         valid;
    logic                         ready;
    logic [cfca_pkg::BYTE_W-1:0]  rx_byte;
    logic                         frame_start;
    logic                         calibrate_request;

    modport source (output valid, rx_byte, frame_start, calibrate_request, input ready);
    modport sink   (input valid, rx_byte, frame_start, calibrate_request, output ready);
endinterface

interface cfca_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [cfca_pkg::CONC_W-1:0]  concentration;
    logic [cfca_pkg::READING_W-1:0]      raw_reading;
    logic                                frame_good;
    logic                                calibrated;

    modport source (output valid, concentration, raw_reading, frame_good, calibrated,
                    input ready);
    modport sink   (input valid, concentration, raw_reading, frame_good, calibrated,
                    output ready);
endinterface

[hw/rtl/cfca_cell.sv]
// ----------------------------------------------------------------------------
// cfca_cell
// One sample slot of the averaging window; passes its sample to the neighbor.
// ----------------------------------------------------------------------------
module cfca_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_shift,
    input  logic [cfca_pkg::READING_W-1:0]  i_sample,
    output logic [cfca_pkg::READING_W-1:0]  o_sample
);

    logic [cfca_pkg::READING_W-1:0] r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_shift) begin
            r_sample <= i_sample;
        end
    end

    assign o_sample = r_sample;

endmodule

[hw/rtl/cfca_rx.sv]
// ----------------------------------------------------------------------------
// cfca_rx
// Frame parser: byte position, checksum, reading capture, calibration request.
// ----------------------------------------------------------------------------
module cfca_rx (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic [cfca_pkg::BYTE_W-1:0]   i_rx_byte,
    input  logic                          i_frame_start,
    input  logic                          i_cal_req,
    output cfca_pkg::t_frame_evt          o_evt,
    output logic                          o_at_last
);

    logic [cfca_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [cfca_pkg::BYTE_W-1:0] r_acc, n_acc;
    logic [cfca_pkg::BYTE_W-1:0] r_high, n_high;
    logic [cfca_pkg::BYTE_W-1:0] r_low, n_low;
    logic                        r_pend, n_pend;
    logic                        w_pend;
    logic [cfca_pkg::BYTE_W-1:0] w_expect;

    always_comb begin
        n_pos    = r_pos;
        n_acc    = r_acc;
        n_high   = r_high;
        n_low    = r_low;
        o_evt    = '0;
        // request latches ahead of the byte itself
        w_pend   = r_pend | (i_take & i_cal_req);
        w_expect = cfca_pkg::BYTE_W'(0) - r_acc;
        if (i_take) begin
            if (i_frame_start) begin
                n_pos = cfca_pkg::POS_FIRST;
                n_acc = '0;
            end else if (r_pos == '0 || r_pos >= cfca_pkg::POS_IDLE) begin
                n_pos = cfca_pkg::POS_IDLE;
            end else if (r_pos < cfca_pkg::POS_LAST) begin
                n_acc = r_acc + i_rx_byte;
                if (r_pos == cfca_pkg::POS_HIGH) begin
                    n_high = i_rx_byte;
                end
                if (r_pos == cfca_pkg::POS_LOW) begin
                    n_low = i_rx_byte;
                end
                n_pos = r_pos + cfca_pkg::POS_W'(1);
            end else begin
                n_pos       = cfca_pkg::POS_IDLE;
                o_evt.valid = 1'b1;
                o_evt.raw   = {r_high, r_low};
                o_evt.good  = (w_expect == i_rx_byte);
                o_evt.cal   = (w_expect == i_rx_byte) & w_pend;
            end
        end
        n_pend = w_pend & ~(o_evt.valid & o_evt.good);
    end

    assign o_at_last = (r_pos == cfca_pkg::POS_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_acc  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_acc  <= n_acc;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_high <= n_high;
        r_low  <= n_low;
    end

endmodule

[hw/rtl/co2_frame_check_average_calibrate_unit.sv]
// ----------------------------------------------------------------------------
// co2_frame_check_average_calibrate_unit
// Checks nine-byte CO2 sensor frames, averages good readings over a window of
// samples and applies a calibrated offset.
//
//   channel  dir  payload                                           transfer
//   i_in     in   rx_byte, frame_start, calibrate_request           valid & ready
//   o_out    out  concentration, raw_reading, frame_good, calibrated valid & ready
//   i_cfg    in   i_cfg_wdata (calibration base)                    i_cfg_we
//
// One byte is taken per cycle while i_in.ready is high. After a frame's last byte
// transfers, its result passes the window sum, reciprocal multiply and offset add
// registers to o_out. The offset update of a calibrating frame lands in the cycle
// after its result shows. The last byte of a frame waits only while the previous
// result is untaken. Reset is synchronous; the window clears at once, no sweep.
// ----------------------------------------------------------------------------
module co2_frame_check_average_calibrate_unit #(
    parameter int WINDOW_SIZE = cfca_pkg::WINDOW_SIZE_D
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    cfca_in_if.sink                       i_in,
    cfca_out_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  logic [cfca_pkg::BASE_W-1:0]   i_cfg_wdata
);

    localparam int LOG_W   = $clog2(WINDOW_SIZE);
    localparam int SUM_W   = cfca_pkg::READING_W + LOG_W;
    localparam int SHIFT   = SUM_W + LOG_W;
    localparam int MULT_W  = SUM_W + 1;
    localparam int PROD_W  = SUM_W + MULT_W;
    localparam int MULT_I  = (2 ** SHIFT + WINDOW_SIZE - 1) / WINDOW_SIZE;
    localparam logic [MULT_W-1:0] MULT_K = MULT_W'(MULT_I);

    localparam int CONC_W = cfca_pkg::CONC_W;
    localparam int OFFS_W = cfca_pkg::OFFS_W;
    localparam int RD_W   = cfca_pkg::READING_W;

    logic                          w_take;
    logic                          w_rx_last;
    cfca_pkg::t_frame_evt          w_evt;
    logic                          w_shift;
    logic [RD_W-1:0]               w_win [WINDOW_SIZE];

    logic [cfca_pkg::BASE_W-1:0]   r_cal_base;
    logic [SUM_W-1:0]              r_wsum;
    logic                          r_a_valid, r_a_good, r_a_cal;
    logic [RD_W-1:0]               r_a_raw;
    logic                          r_b_valid, r_b_good, r_b_cal;
    logic [RD_W-1:0]               r_b_raw;
    logic [PROD_W-1:0]             r_b_prod;
    logic                          r_out_valid, r_out_good, r_out_cal;
    logic signed [CONC_W-1:0]      r_out_conc;
    logic [RD_W-1:0]               r_out_raw;
    logic                          r_cal_upd;
    logic signed [CONC_W-1:0]      r_offset;

    logic [RD_W-1:0]               w_quot;
    logic signed [CONC_W:0]        w_csum;
    logic signed [CONC_W-1:0]      w_conc;
    logic signed [OFFS_W-1:0]      w_oadj;
    logic signed [CONC_W-1:0]      n_offset;

    // last byte stalls only while the result slot is still occupied
    assign i_in.ready = !w_rx_last || !r_out_valid || o_out.ready;
    assign w_take     = i_in.valid && i_in.ready;

    cfca_rx u_rx (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (w_take),
        .i_rx_byte     (i_in.rx_byte),
        .i_frame_start (i_in.frame_start),
        .i_cal_req     (i_in.calibrate_request),
        .o_evt         (w_evt),
        .o_at_last     (w_rx_last)
    );

    assign w_shift = w_evt.valid & w_evt.good;

    // sample chain: newest enters the top cell, oldest sits in cell 0
    for (genvar g = 0; g < WINDOW_SIZE; g++) begin : g_cell
        if (g == WINDOW_SIZE - 1) begin : g_top
            cfca_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_shift  (w_shift),
                .i_sample (w_evt.raw),
                .o_sample (w_win[g])
            );
        end else begin : g_mid
            cfca_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_shift  (w_shift),
                .i_sample (w_win[g+1]),
                .o_sample (w_win[g])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_base <= cfca_pkg::CAL_BASE_RST;
        end else if (i_cfg_we) begin
            r_cal_base <= i_cfg_wdata;
        end
    end

    // stage A: window sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsum    <= '0;
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= w_evt.valid;
            if (w_shift) begin
                r_wsum <= r_wsum - SUM_W'(w_win[0]) + SUM_W'(w_evt.raw);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_good <= w_evt.good;
        r_a_cal  <= w_evt.cal;
        r_a_raw  <= w_evt.raw;
    end

    // stage B: divide by window size through reciprocal multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_good <= r_a_good;
        r_b_cal  <= r_a_cal;
        r_b_raw  <= r_a_raw;
        r_b_prod <= PROD_W'(r_wsum) * PROD_W'(MULT_K);
    end

    // stage C: offset add and saturation
    always_comb begin
        w_quot = r_b_prod[SHIFT +: RD_W];
        w_csum = $signed({{(CONC_W + 1 - RD_W){1'b0}}, w_quot})
               + $signed({r_offset[CONC_W-1], r_offset});
        if (!r_b_good) begin
            w_conc = '0;
        end else if (w_csum[CONC_W] != w_csum[CONC_W-1]) begin
            w_conc = w_csum[CONC_W] ? cfca_pkg::CONC_MIN : cfca_pkg::CONC_MAX;
        end else begin
            w_conc = w_csum[CONC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cal_upd   <= 1'b0;
        end else begin
            r_cal_upd <= r_b_valid & r_b_good & r_b_cal;
            if (r_b_valid) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_out_conc <= w_conc;
            r_out_raw  <= r_b_raw;
            r_out_good <= r_b_good;
            r_out_cal  <= r_b_cal;
        end
    end

    // stage D: calibration moves the offset so the output would read the base
    always_comb begin
        w_oadj = OFFS_W'(r_offset) + $signed({{(OFFS_W - cfca_pkg::BASE_W){1'b0}}, r_cal_base})
               - OFFS_W'(r_out_conc);
        if (w_oadj[OFFS_W-1:CONC_W-1] != {(OFFS_W - CONC_W + 1){w_oadj[OFFS_W-1]}}) begin
            n_offset = w_oadj[OFFS_W-1] ? cfca_pkg::CONC_MIN : cfca_pkg::CONC_MAX;
        end else begin
            n_offset = w_oadj[CONC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (r_cal_upd) begin
            r_offset <= n_offset;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.concentration = r_out_conc;
    assign o_out.raw_reading   = r_out_raw;
    assign o_out.frame_good    = r_out_good;
    assign o_out.calibrated    = r_out_cal;

    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (!r_out_valid || o_out.ready))
        else $error("result arrived while output slot still held");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_a_valid, r_b_valid, r_cal_upd}))
        else $error("more than one frame result in flight");

    a_bad_keeps_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !r_a_good) |-> (r_wsum == $past(r_wsum)))
        else $error("rejected frame changed window sum");

endmodule
